[design/srr_pkg.sv]
// Shared types and constants of the selective repeat receiver.
`timescale 1ns / 1ps

package srr_pkg;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam int CFG_W = 4;
    localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd8;

    typedef struct packed {
        logic [7:0]  seq;
        logic [63:0] low;
        logic [63:0] mid;
        logic [31:0] high;
    } t_pkt;

    typedef struct packed {
        logic               kind;
        logic [7:0]         ack_number;
        logic signed [31:0] ack_check;
        logic [7:0]         deliver_seq;
        logic [63:0]        data_low;
        logic [63:0]        data_mid;
        logic [31:0]        data_high;
        logic               last;
    } t_result;

endpackage

[design/srr_front.sv]
// Front end: accepts packets, verifies the checksum over two stages and queues good ones.
`timescale 1ns / 1ps

module srr_front import srr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [7:0]         i_seq_num,
    input  logic signed [31:0] i_ack_field,
    input  logic signed [31:0] i_check_value,
    input  logic [63:0]        i_payload_low,
    input  logic [63:0]        i_payload_mid,
    input  logic [31:0]        i_payload_high,
    input  logic               i_full,
    output logic               o_busy,
    output logic               o_push,
    output t_pkt               o_pkt
);

    function automatic logic signed [10:0] sum8(input logic [63:0] w);
        logic signed [10:0] s;
        s = '0;
        for (int i = 0; i < 8; i++) begin
            s = s + {{3{w[8*i+7]}}, w[8*i +: 8]};
        end
        return s;
    endfunction

    function automatic logic signed [9:0] sum4(input logic [31:0] w);
        logic signed [9:0] s;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            s = s + {{2{w[8*i+7]}}, w[8*i +: 8]};
        end
        return s;
    endfunction

    logic        r_a_valid;
    t_pkt        r_a_pkt;
    logic [31:0] r_a_ack;
    logic [31:0] r_a_chk;

    logic        r_b_valid;
    t_pkt        r_b_pkt;
    logic [31:0] r_b_p0;
    logic [31:0] r_b_p1;
    logic [31:0] r_b_p2;
    logic [31:0] r_b_chk;

    logic        accept;
    logic        b_ok;
    logic        b_done;
    logic        b_load;
    logic        a_move;
    logic        n_a_valid;
    logic        n_b_valid;
    logic signed [10:0] s_low;
    logic signed [10:0] s_mid;
    logic signed [9:0]  s_high;

    assign b_ok   = (~(r_b_p0 + r_b_p1 + r_b_p2)) == r_b_chk;
    assign b_done = r_b_valid && (!b_ok || !i_full);
    assign o_push = r_b_valid && b_ok && !i_full;
    assign o_pkt  = r_b_pkt;

    assign b_load = !r_b_valid || b_done;
    assign a_move = r_a_valid && b_load;
    assign o_busy = r_a_valid && !a_move;
    assign accept = i_start && !o_busy;

    assign n_a_valid = accept || (r_a_valid && !a_move);
    assign n_b_valid = a_move || (r_b_valid && !b_done);

    assign s_low  = sum8(r_a_pkt.low);
    assign s_mid  = sum8(r_a_pkt.mid);
    assign s_high = sum4(r_a_pkt.high);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_pkt.seq  <= i_seq_num;
            r_a_pkt.low  <= i_payload_low;
            r_a_pkt.mid  <= i_payload_mid;
            r_a_pkt.high <= i_payload_high;
            r_a_ack      <= i_ack_field;
            r_a_chk      <= i_check_value;
        end
        if (a_move) begin
            r_b_pkt <= r_a_pkt;
            r_b_chk <= r_a_chk;
            r_b_p0  <= {{21{s_low[10]}}, s_low};
            r_b_p1  <= {{21{s_mid[10]}}, s_mid};
            r_b_p2  <= {24'b0, r_a_pkt.seq} + r_a_ack + {{22{s_high[9]}}, s_high};
        end
    end

endmodule

[design/srr_queue.sv]
// Two-entry queue of verified packets between the front and back ends.
`timescale 1ns / 1ps

module srr_queue import srr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_pkt i_pkt,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_pkt o_pkt
);

    localparam int DEPTH = 2;

    t_pkt       r_mem [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = r_count == 2'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_pkt   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pkt;
        end
    end

endmodule

[design/srr_back.sv]
// Back end: window classification, slot store and in-order delivery sequencer.
`timescale 1ns / 1ps

module srr_back import srr_pkg::*; #(
    parameter int WINDOW_MAX = 8,
    parameter int SEQ_BITS   = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_window_size,
    output logic             o_cfg_ready,
    input  logic             i_empty,
    input  t_pkt             i_pkt,
    output logic             o_pop,
    output logic             o_res_valid,
    output t_result          o_res
);

    localparam int IW    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WW    = $clog2(WINDOW_MAX + 1);
    localparam int HALF  = 1 << (SEQ_BITS - 1);
    localparam int LIMIT = (WINDOW_MAX < HALF) ? WINDOW_MAX : HALF;
    localparam int CW    = (SEQ_BITS > WW) ? SEQ_BITS : WW;
    localparam logic [IW-1:0] LAST_SLOT = IW'(WINDOW_MAX - 1);

    typedef struct packed {
        logic [63:0] low;
        logic [63:0] mid;
        logic [31:0] high;
    } t_slot;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_CLASS = 3'b010,
        ST_EMIT  = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [CFG_W-1:0]      r_window_size;
    logic [SEQ_BITS-1:0]   r_base, n_base;
    logic [IW-1:0]         r_head, n_head;
    logic [WW-1:0]         r_cnt, n_cnt;
    logic [WINDOW_MAX-1:0] r_filled, n_filled;
    logic                  r_res_valid, n_res_valid;
    t_result               r_res, n_res;
    t_pkt                  r_pkt;
    t_slot                 r_mem [WINDOW_MAX];
    t_slot                 r_rd;

    logic [WW-1:0]       win;
    logic [SEQ_BITS-1:0] seq;
    logic [SEQ_BITS-1:0] ahead;
    logic [SEQ_BITS-1:0] behind;
    logic                in_win;
    logic                in_prev;
    logic [IW:0]         slot_sum;
    logic [IW-1:0]       slot_idx;
    logic [IW-1:0]       head_next;
    logic [IW-1:0]       rd_addr;
    logic                filled0;
    logic [WW-1:0]       cnt_next;
    logic                more;
    logic                we;
    t_slot               wdata;
    t_result             ack_res;
    t_result             data_res;

    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        if (int'(r_window_size) > LIMIT) begin
            win = WW'(LIMIT);
        end else if (r_window_size == '0) begin
            win = WW'(1);
        end else begin
            win = WW'(r_window_size);
        end
    end

    assign seq     = SEQ_BITS'(r_pkt.seq);
    assign ahead   = seq - r_base;
    assign behind  = r_base - seq;
    assign in_win  = CW'(ahead) < CW'(win);
    assign in_prev = (behind != '0) && (CW'(behind) <= CW'(win));

    assign slot_sum = {1'b0, r_head} + (IW+1)'(ahead);
    assign slot_idx = (slot_sum >= (IW+1)'(WINDOW_MAX))
                    ? IW'(slot_sum - (IW+1)'(WINDOW_MAX)) : IW'(slot_sum);

    assign head_next = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
    assign filled0   = r_filled[r_head] || (ahead == '0);
    assign cnt_next  = r_cnt + 1'b1;
    assign more      = (cnt_next < win) && r_filled[head_next] && (head_next != r_head);

    assign wdata.low  = r_pkt.low;
    assign wdata.mid  = r_pkt.mid;
    assign wdata.high = r_pkt.high;

    always_comb begin
        ack_res            = '0;
        ack_res.kind       = KIND_ACK;
        ack_res.ack_number = 8'(seq);
        ack_res.ack_check  = ~32'(seq);

        data_res             = '0;
        data_res.kind        = KIND_DATA;
        data_res.deliver_seq = 8'(r_base);
        data_res.data_low    = r_rd.low;
        data_res.data_mid    = r_rd.mid;
        data_res.data_high   = r_rd.high;
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_filled    = r_filled;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        we          = 1'b0;
        rd_addr     = r_head;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_cnt = '0;
                if (in_win) begin
                    n_res_valid = 1'b1;
                    n_res       = ack_res;
                    n_res.last  = !filled0;
                    if (!r_filled[slot_idx]) begin
                        we                 = 1'b1;
                        n_filled[slot_idx] = 1'b1;
                    end
                    n_state = filled0 ? ST_EMIT : ST_IDLE;
                end else begin
                    if (in_prev) begin
                        n_res_valid = 1'b1;
                        n_res       = ack_res;
                        n_res.last  = 1'b1;
                    end
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                rd_addr          = head_next;
                n_res_valid      = 1'b1;
                n_res            = data_res;
                n_res.last       = !more;
                n_filled[r_head] = 1'b0;
                n_head           = head_next;
                n_base           = r_base + 1'b1;
                n_cnt            = cnt_next;
                n_state          = more ? ST_EMIT : ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_window_size <= WINDOW_RESET;
            r_base        <= '0;
            r_head        <= '0;
            r_cnt         <= '0;
            r_filled      <= '0;
            r_res_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_filled    <= n_filled;
            r_res_valid <= n_res_valid;
            if (i_cfg_valid) begin
                r_window_size <= i_cfg_window_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (o_pop) begin
            r_pkt <= i_pkt;
        end
    end

    // Slot store with a write-first read port.
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[slot_idx] <= wdata;
        end
        if (we && (slot_idx == rd_addr)) begin
            r_rd <= wdata;
        end else begin
            r_rd <= r_mem[rd_addr];
        end
    end

endmodule

[design/selective_repeat_receiver.sv]
// Top level of the selective repeat receiver.
`timescale 1ns / 1ps

// A packet is taken at a clock edge where start is high and busy is low. The
// front end checks its checksum in a registered pipeline and drops it if the
// check fails; good packets wait in a two-entry queue for the back end.
// Each result is shown for exactly one cycle with o_result_valid high. The
// receiver cannot hold results off, and o_last marks the final result of a
// packet. The acknowledgement of an accepted packet passes through the front
// end's stage registers, the queue, the back end's packet register and the
// result register; deliveries then follow one a cycle.
// For each packet the back end takes it from the queue, classifies and stores
// it, then reads each delivery from the slot store; it takes the next packet
// from the queue only once it is back in idle.
// busy rises only while the queue is full, so a short burst of packets is
// absorbed while the back end is delivering.
// The window size register is written through its own channel, whose ready is
// always high; write it only while the block is idle: the block does not enforce it.
// Reset sets the window size to 8, the window base to zero and empties every
// slot.

module selective_repeat_receiver import srr_pkg::*; #(
    parameter int WINDOW_MAX = 8,
    parameter int SEQ_BITS   = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [7:0]         i_seq_num,
    input  logic signed [31:0] i_ack_field,
    input  logic signed [31:0] i_check_value,
    input  logic [63:0]        i_payload_low,
    input  logic [63:0]        i_payload_mid,
    input  logic [31:0]        i_payload_high,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_window_size,
    output logic               o_result_valid,
    output logic               o_kind,
    output logic [7:0]         o_ack_number,
    output logic signed [31:0] o_ack_check,
    output logic [7:0]         o_deliver_seq,
    output logic [63:0]        o_data_low,
    output logic [63:0]        o_data_mid,
    output logic [31:0]        o_data_high,
    output logic               o_last
);

    logic    push;
    logic    pop;
    logic    full;
    logic    empty;
    t_pkt    front_pkt;
    t_pkt    queue_pkt;
    t_result res;

    srr_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_seq_num      (i_seq_num),
        .i_ack_field    (i_ack_field),
        .i_check_value  (i_check_value),
        .i_payload_low  (i_payload_low),
        .i_payload_mid  (i_payload_mid),
        .i_payload_high (i_payload_high),
        .i_full         (full),
        .o_busy         (busy),
        .o_push         (push),
        .o_pkt          (front_pkt)
    );

    srr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pkt   (front_pkt),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_pkt   (queue_pkt)
    );

    srr_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .SEQ_BITS   (SEQ_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_window_size (i_cfg_window_size),
        .o_cfg_ready       (o_cfg_ready),
        .i_empty           (empty),
        .i_pkt             (queue_pkt),
        .o_pop             (pop),
        .o_res_valid       (o_result_valid),
        .o_res             (res)
    );

    assign o_kind        = res.kind;
    assign o_ack_number  = res.ack_number;
    assign o_ack_check   = res.ack_check;
    assign o_deliver_seq = res.deliver_seq;
    assign o_data_low    = res.data_low;
    assign o_data_mid    = res.data_mid;
    assign o_data_high   = res.data_high;
    assign o_last        = res.last;

endmodule

[verif/tb_selective_repeat_receiver.sv]
// Self-checking testbench for the selective repeat receiver, with a built-in window predictor.
`timescale 1ns / 1ps

module tb_selective_repeat_receiver;
    import srr_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int SETTLE       = 40;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SLOTS        = 8;
    localparam int BATCH_QUOTA  = 9;

    typedef struct packed {
        logic [7:0]  seq;
        logic [31:0] ack;
        logic [31:0] check;
        logic [63:0] low;
        logic [63:0] mid;
        logic [31:0] high;
    } rx_packet_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [7:0]         i_seq_num = '0;
    logic signed [31:0] i_ack_field = '0;
    logic signed [31:0] i_check_value = '0;
    logic [63:0]        i_payload_low = '0;
    logic [63:0]        i_payload_mid = '0;
    logic [31:0]        i_payload_high = '0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_window_size = '0;
    logic               o_result_valid;
    logic               o_kind;
    logic [7:0]         o_ack_number;
    logic signed [31:0] o_ack_check;
    logic [7:0]         o_deliver_seq;
    logic [63:0]        o_data_low;
    logic [63:0]        o_data_mid;
    logic [31:0]        o_data_high;
    logic               o_last;

    selective_repeat_receiver dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_seq_num         (i_seq_num),
        .i_ack_field       (i_ack_field),
        .i_check_value     (i_check_value),
        .i_payload_low     (i_payload_low),
        .i_payload_mid     (i_payload_mid),
        .i_payload_high    (i_payload_high),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_window_size (i_cfg_window_size),
        .o_result_valid    (o_result_valid),
        .o_kind            (o_kind),
        .o_ack_number      (o_ack_number),
        .o_ack_check       (o_ack_check),
        .o_deliver_seq     (o_deliver_seq),
        .o_data_low        (o_data_low),
        .o_data_mid        (o_data_mid),
        .o_data_high       (o_data_high),
        .o_last            (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Receiver state as the predictor sees it.
    logic [CFG_W-1:0] window_reg = WINDOW_RESET;
    logic [7:0]       window_base = '0;
    logic             slot_full [0:SLOTS-1];
    logic [63:0]      slot_low  [0:SLOTS-1];
    logic [63:0]      slot_mid  [0:SLOTS-1];
    logic [31:0]      slot_high [0:SLOTS-1];

    rx_packet_t tx_backlog [$];
    t_result    owed_results [$];
    rx_packet_t live_pkt;
    t_result    due;
    int         pkts_outstanding = 0;
    int         idle_left = 0;
    int         quiet_cycles = 0;
    int         errors = 0;
    bit         burst = 1'b0;

    initial begin
        for (int k = 0; k < SLOTS; k++) begin
            slot_full[k] = 1'b0;
            slot_low[k]  = '0;
            slot_mid[k]  = '0;
            slot_high[k] = '0;
        end
    end

    function automatic logic [31:0] byte_total(logic [159:0] bytes);
        logic [31:0] sum;
        sum = '0;
        for (int i = 0; i < 20; i++) begin
            sum += {{24{bytes[8*i+7]}}, bytes[8*i +: 8]};
        end
        return sum;
    endfunction

    function automatic logic [31:0] packet_check(rx_packet_t p);
        return ~({24'b0, p.seq} + p.ack + byte_total({p.high, p.mid, p.low}));
    endfunction

    function automatic int unsigned live_window();
        if (window_reg < 1) return 1;
        if (window_reg > SLOTS) return SLOTS;
        return int'(window_reg);
    endfunction

    function automatic t_result ack_result(logic [7:0] seq);
        t_result r;
        r = '0;
        r.kind = KIND_ACK;
        r.ack_number = seq;
        r.ack_check = ~{24'b0, seq};
        return r;
    endfunction

    // Works out the results one accepted packet causes and updates the window.
    task automatic absorb_packet(input rx_packet_t p);
        t_result     row [0:SLOTS];
        int          n;
        int unsigned win;
        int unsigned shipped;
        logic [7:0]  ahead;
        logic [7:0]  behind;
        n = 0;
        win = live_window();
        ahead = p.seq - window_base;
        behind = window_base - p.seq;
        if (packet_check(p) == p.check) begin
            if (ahead < win) begin
                row[n] = ack_result(p.seq);
                n++;
                if (!slot_full[ahead]) begin
                    slot_full[ahead] = 1'b1;
                    slot_low[ahead]  = p.low;
                    slot_mid[ahead]  = p.mid;
                    slot_high[ahead] = p.high;
                end
                shipped = 0;
                while (shipped < win && slot_full[0]) begin
                    row[n] = '0;
                    row[n].kind = KIND_DATA;
                    row[n].deliver_seq = window_base;
                    row[n].data_low  = slot_low[0];
                    row[n].data_mid  = slot_mid[0];
                    row[n].data_high = slot_high[0];
                    n++;
                    window_base++;
                    for (int k = 0; k < SLOTS - 1; k++) begin
                        slot_full[k] = slot_full[k+1];
                        slot_low[k]  = slot_low[k+1];
                        slot_mid[k]  = slot_mid[k+1];
                        slot_high[k] = slot_high[k+1];
                    end
                    slot_full[SLOTS-1] = 1'b0;
                    slot_low[SLOTS-1]  = '0;
                    slot_mid[SLOTS-1]  = '0;
                    slot_high[SLOTS-1] = '0;
                    shipped++;
                end
            end else if (behind >= 1 && behind <= win) begin
                row[n] = ack_result(p.seq);
                n++;
            end
        end
        for (int i = 0; i < n; i++) begin
            row[i].last = (i == n - 1);
            owed_results.push_back(row[i]);
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                absorb_packet(live_pkt);
                pkts_outstanding--;
            end
            if (!start || !busy) begin
                if (idle_left > 0) begin
                    idle_left--;
                    start <= 1'b0;
                end else if (tx_backlog.size() > 0) begin
                    live_pkt = tx_backlog.pop_front();
                    i_seq_num      <= live_pkt.seq;
                    i_ack_field    <= live_pkt.ack;
                    i_check_value  <= live_pkt.check;
                    i_payload_low  <= live_pkt.low;
                    i_payload_mid  <= live_pkt.mid;
                    i_payload_high <= live_pkt.high;
                    start <= 1'b1;
                    idle_left = pick_gap();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (owed_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, kind %0d", o_kind));
            end else begin
                due = owed_results.pop_front();
                check_field("kind", o_kind, due.kind);
                check_field("ack_number", o_ack_number, due.ack_number);
                check_field("ack_check", o_ack_check, due.ack_check);
                check_field("deliver_seq", o_deliver_seq, due.deliver_seq);
                check_field("data_low", o_data_low, due.data_low);
                check_field("data_mid", o_data_mid, due.data_mid);
                check_field("data_high", o_data_high, due.data_high);
                check_field("last", o_last, due.last);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic rx_packet_t make_packet(logic [7:0] seq, logic [31:0] ack,
                                               logic [63:0] low, logic [63:0] mid,
                                               logic [31:0] high, bit good);
        rx_packet_t p;
        p.seq = seq;
        p.ack = ack;
        p.low = low;
        p.mid = mid;
        p.high = high;
        p.check = packet_check(p);
        if (!good) p.check ^= ($urandom | 32'h1);
        return p;
    endfunction

    task automatic queue_packet(input rx_packet_t p);
        pkts_outstanding++;
        tx_backlog.push_back(p);
    endtask

    task automatic queue_seq(input logic [7:0] seq, input bit good);
        queue_packet(make_packet(seq, $urandom, {$urandom, $urandom}, {$urandom, $urandom},
                                 $urandom, good));
    endtask

    task automatic drain();
        wait (pkts_outstanding == 0);
        wait (owed_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_window_size <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        window_reg = value;
    endtask

    // One burst of traffic around the current window: a shuffled pass over the
    // window with losses and duplicates, plus stale, stray and corrupted packets.
    task automatic send_batch(inout int counted);
        int          offs [SLOTS];
        int unsigned win;
        int          j;
        int          tmp;
        int          r;
        wait (pkts_outstanding == 0);
        burst = ($urandom_range(0, 3) == 0);
        win = live_window();
        for (int k = 0; k < win; k++) offs[k] = k;
        for (int k = win - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = offs[k];
            offs[k] = offs[j];
            offs[j] = tmp;
        end
        for (int k = 0; k < win; k++) begin
            r = $urandom_range(0, 99);
            if (r >= 12) begin
                queue_seq(8'(window_base + offs[k]), 1'b1);
                counted++;
            end
            if (r >= 90) begin
                queue_seq(8'(window_base + offs[k]), 1'b1);
                counted++;
            end
        end
        if ($urandom_range(0, 2) == 0) begin
            queue_seq(8'(window_base - $urandom_range(1, win)), 1'b1);
            counted++;
        end
        if ($urandom_range(0, 3) == 0) queue_seq(8'($urandom_range(0, 255)), 1'b1);
        if ($urandom_range(0, 3) == 0) queue_seq(window_base, 1'b0);
    endtask

    initial begin
        logic [CFG_W-1:0] settings [6];
        int counted;
        settings = '{4'd15, 4'd0, 4'd1, 4'd8, 4'd0, 4'd0};
        settings[4] = 4'($urandom_range(0, 15));
        settings[5] = 4'($urandom_range(2, 7));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        queue_packet(make_packet(8'd0, 32'h8000_0000, '1, '1, '1, 1'b1));
        queue_packet(make_packet(8'd2, 32'h7fff_ffff, '0, '0, '0, 1'b1));
        queue_packet(make_packet(8'd2, 32'h0, {8{8'h80}}, {8{8'h7f}}, {4{8'h80}}, 1'b1));
        queue_seq(8'd1, 1'b1);
        queue_seq(8'd3, 1'b0);
        queue_seq(8'd100, 1'b1);
        queue_seq(8'd0, 1'b1);
        queue_packet(make_packet(8'd255, 32'hffff_ffff, '1, '0, '1, 1'b1));
        queue_seq(8'd11, 1'b1);
        queue_seq(8'd250, 1'b1);
        queue_seq(8'd10, 1'b1);
        for (int s = 4; s <= 9; s++) queue_seq(s[7:0], 1'b1);
        drain();

        // Shrinking the window leaves filled slots beyond it, and each packet
        // then releases at most one window's worth of them.
        write_window(4'd2);
        queue_seq(8'd3, 1'b1);
        queue_seq(8'd5, 1'b1);
        queue_seq(8'd7, 1'b1);
        queue_seq(8'd9, 1'b1);
        drain();

        foreach (settings[i]) begin
            write_window(settings[i]);
            counted = 0;
            while (counted < BATCH_QUOTA) send_batch(counted);
            drain();
        end

        if (errors == 0 && owed_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
